@@ src/ibl_pkg.sv @@
// Package for the irrigation bandit learner: state type, edges, rewards, durations.
// No dependencies.
package ibl_pkg;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_DIV,
        S_WRITE,
        S_DONE
    } t_state;

    localparam int CELLS = 25;

    localparam logic [1:0] KIND_MONITOR   = 2'd0;
    localparam logic [1:0] KIND_IRRIGATE  = 2'd1;
    localparam logic [1:0] KIND_EMERGENCY = 2'd2;

    localparam logic [14:0] EDGE_20 = 15'd5120;
    localparam logic [14:0] EDGE_30 = 15'd7680;
    localparam logic [14:0] EDGE_40 = 15'd10240;
    localparam logic [14:0] EDGE_45 = 15'd11520;
    localparam logic [14:0] EDGE_50 = 15'd12800;
    localparam logic signed [15:0] CHG_5  = 16'sd1280;
    localparam logic signed [15:0] CHG_10 = 16'sd2560;
    localparam logic signed [15:0] CHG_20 = 16'sd5120;
    localparam logic signed [15:0] CHG_30 = 16'sd7680;

    localparam logic signed [15:0] R_POS_1    = 16'sd16384;
    localparam logic signed [15:0] R_HALF     = 16'sd8192;
    localparam logic signed [15:0] R_QUARTER  = 16'sd4096;
    localparam logic signed [15:0] R_NEG_03   = -16'sd4915;
    localparam logic signed [15:0] R_NEG_HALF = -16'sd8192;
    localparam logic signed [15:0] R_NEG_1    = -16'sd16384;

    function automatic logic [3:0] dur_of(input logic [2:0] a);
        logic [3:0] d;
        case (a)
            3'd0: d = 4'd2;
            3'd1: d = 4'd4;
            3'd2: d = 4'd6;
            3'd3: d = 4'd8;
            3'd4: d = 4'd10;
            default: d = 4'd2;
        endcase
        return d;
    endfunction

    function automatic logic [2:0] bin_of(input logic [14:0] m);
        logic [2:0] b;
        if (m < EDGE_20) b = 3'd0;
        else if (m < EDGE_30) b = 3'd1;
        else if (m < EDGE_40) b = 3'd2;
        else if (m < EDGE_50) b = 3'd3;
        else b = 3'd4;
        return b;
    endfunction

    // fold hex digits (16 is 1 modulo 5), then reduce by compare and subtract
    function automatic logic [2:0] mod5(input logic [18:0] v);
        logic [6:0] s1;
        logic [4:0] s2;
        logic [4:0] r;
        s1 = 7'(v[3:0]) + 7'(v[7:4]) + 7'(v[11:8]) + 7'(v[15:12]) + 7'(v[18:16]);
        s2 = 5'(s1[6:4]) + 5'(s1[3:0]);
        if (s2 >= 5'd15) r = s2 - 5'd15;
        else if (s2 >= 5'd10) r = s2 - 5'd10;
        else if (s2 >= 5'd5) r = s2 - 5'd5;
        else r = s2;
        return r[2:0];
    endfunction

endpackage

@@ src/irrigation_bandit_learner.sv @@
// Irrigation bandit learner top level: sequencer, score/count tables, serial divider.
// Depends on ibl_pkg.
//
// One transaction at a time; busy is high from acceptance through the result strobe.
// Emergency, monitoring and non-irrigated learn transactions go straight from idle to
// the result strobe. An irrigating decide scans the five cells of its bin through one
// shared adder/compare: one pass summing counts while exploring, a second pass comparing
// scores when picking the best score. An irrigated learn transaction loads and runs a
// 17-step restoring divider for (reward - score)/(n+1), then writes back before its
// strobe. The next transaction can be accepted once the block is back in idle after
// the strobe. The result is shown for one cycle on o_valid and cannot be stalled.
// Tables are cleared at reset.
module irrigation_bandit_learner (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic        i_cfg_we,
    input  logic [5:0]  i_cfg_data,
    input  logic        i_op,
    input  logic        i_system_healthy,
    input  logic        i_water_available,
    input  logic [14:0] i_moisture,
    input  logic [14:0] i_prev_moisture,
    input  logic        i_prev_irrigated,
    input  logic [3:0]  i_prev_duration,
    output logic        o_valid,
    output logic [1:0]  o_decision_kind,
    output logic        o_irrigate,
    output logic        o_emergency,
    output logic [3:0]  o_duration,
    output logic        o_learned
);
    localparam int IW = $clog2(ibl_pkg::CELLS);

    ibl_pkg::t_state r_state, n_state;
    logic [15:0] r_score [ibl_pkg::CELLS];
    logic [15:0] r_count [ibl_pkg::CELLS];
    logic [5:0]  r_expl;
    logic [IW-1:0] r_base;
    logic [2:0]  r_a, r_best;
    logic        r_pass;
    logic [18:0] r_total;
    logic signed [15:0] r_bscore;
    logic [IW-1:0] r_idx;
    logic signed [15:0] r_old;
    logic signed [15:0] r_rew;
    logic [16:0] r_den, r_quo;
    logic [17:0] r_rem;
    logic [16:0] r_num;
    logic        r_neg;
    logic [4:0]  r_step;
    logic [3:0]  r_dur;
    logic        r_kind_irr, r_learn;

    logic [IW-1:0] w_cell;
    logic [IW-1:0] w_lidx;
    logic signed [15:0] w_s;
    logic [17:0] w_trial;
    logic        w_scan_last;
    logic signed [15:0] w_rew, w_d;
    logic [2:0]  w_act, w_pbin, w_mbin;
    logic signed [17:0] w_diff;
    logic signed [16:0] w_q;

    assign w_cell = r_base + IW'(r_a);
    assign w_lidx = IW'({2'b00, w_pbin} * 5'd5 + {2'b00, w_act});
    assign w_s = $signed(r_score[w_cell]);
    assign w_scan_last = (r_a == 3'd4);
    assign w_trial = {r_rem[16:0], r_num[16]} - {1'b0, r_den};
    assign w_q = r_neg ? -$signed(r_quo) : $signed(r_quo);
    assign w_pbin = ibl_pkg::bin_of(i_prev_moisture);
    assign w_mbin = ibl_pkg::bin_of(i_moisture);
    assign w_d = $signed({1'b0, i_moisture}) - $signed({1'b0, i_prev_moisture});

    always_comb begin
        w_act = 3'd0;
        for (int a = 4; a >= 0; a--) begin
            if (i_prev_duration == ibl_pkg::dur_of(3'(a))) w_act = 3'(a);
        end
        if (i_prev_moisture < ibl_pkg::EDGE_30) begin
            if (w_d >= ibl_pkg::CHG_10 && w_d <= ibl_pkg::CHG_30) w_rew = ibl_pkg::R_POS_1;
            else if (w_d > ibl_pkg::CHG_30) w_rew = ibl_pkg::R_QUARTER;
            else w_rew = ibl_pkg::R_NEG_HALF;
        end else if (i_prev_moisture >= ibl_pkg::EDGE_45) begin
            if (w_d > ibl_pkg::CHG_10) w_rew = ibl_pkg::R_NEG_1;
            else w_rew = ibl_pkg::R_HALF;
        end else begin
            if (w_d >= ibl_pkg::CHG_5 && w_d <= ibl_pkg::CHG_20) w_rew = ibl_pkg::R_POS_1;
            else if (w_d > ibl_pkg::CHG_20) w_rew = ibl_pkg::R_QUARTER;
            else w_rew = ibl_pkg::R_NEG_03;
        end
        w_diff = 18'(r_rew) - 18'(r_old);
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            ibl_pkg::S_IDLE: begin
                if (start) begin
                    if (i_op) n_state = i_prev_irrigated ? ibl_pkg::S_DIV : ibl_pkg::S_DONE;
                    else if (i_system_healthy && i_water_available) n_state = ibl_pkg::S_SCAN;
                    else n_state = ibl_pkg::S_DONE;
                end
            end
            ibl_pkg::S_SCAN: begin
                if (w_scan_last && (r_pass || r_total + 19'(r_count[w_cell]) < 19'(r_expl)))
                    n_state = ibl_pkg::S_DONE;
            end
            ibl_pkg::S_DIV:   if (r_step == 5'd17) n_state = ibl_pkg::S_WRITE;
            ibl_pkg::S_WRITE: n_state = ibl_pkg::S_DONE;
            ibl_pkg::S_DONE:  n_state = ibl_pkg::S_IDLE;
            default:          n_state = ibl_pkg::S_IDLE;
        endcase
    end

    always_comb begin
        busy = (r_state != ibl_pkg::S_IDLE);
        o_valid = (r_state == ibl_pkg::S_DONE);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ibl_pkg::S_IDLE;
            r_expl  <= 6'd10;
            for (int i = 0; i < ibl_pkg::CELLS; i++) begin
                r_score[i] <= '0;
                r_count[i] <= '0;
            end
            r_kind_irr <= 1'b0;
            r_learn <= 1'b0;
            o_decision_kind <= ibl_pkg::KIND_MONITOR;
            o_irrigate <= 1'b0;
            o_emergency <= 1'b0;
            o_learned <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) r_expl <= i_cfg_data;
            case (r_state)
                ibl_pkg::S_IDLE: begin
                    if (start) begin
                        r_a <= '0;
                        r_pass <= 1'b0;
                        r_total <= '0;
                        r_best <= '0;
                        r_base <= IW'({2'b00, w_mbin} * 5'd5);
                        r_learn <= i_op;
                        r_kind_irr <= !i_op && i_system_healthy && i_water_available;
                        o_emergency <= !i_op && !i_system_healthy;
                        o_decision_kind <= i_op ? ibl_pkg::KIND_MONITOR :
                            !i_system_healthy ? ibl_pkg::KIND_EMERGENCY :
                            i_water_available ? ibl_pkg::KIND_IRRIGATE : ibl_pkg::KIND_MONITOR;
                        o_irrigate <= !i_op && i_system_healthy && i_water_available;
                        o_learned <= i_op && i_prev_irrigated;
                        r_dur <= '0;
                        r_idx <= w_lidx;
                        r_old <= $signed(r_score[w_lidx]);
                        r_rew <= w_rew;
                        r_den <= 17'(r_count[w_lidx]) + 17'd1;
                        r_step <= '0;
                        r_rem <= '0;
                    end
                end
                ibl_pkg::S_SCAN: begin
                    r_a <= w_scan_last ? 3'd0 : r_a + 3'd1;
                    if (!r_pass) begin
                        r_total <= r_total + 19'(r_count[w_cell]);
                        if (w_scan_last) begin
                            r_pass <= 1'b1;
                            r_dur <= ibl_pkg::dur_of(
                                ibl_pkg::mod5(r_total + 19'(r_count[w_cell])));
                        end
                    end else begin
                        if (r_a == 3'd0 || w_s > r_bscore) begin
                            r_bscore <= w_s;
                            r_best <= r_a;
                        end
                        if (w_scan_last)
                            r_dur <= ibl_pkg::dur_of((w_s > r_bscore) ? r_a : r_best);
                    end
                end
                ibl_pkg::S_DIV: begin
                    if (r_step == 5'd0) begin
                        r_neg <= w_diff[17];
                        r_num <= w_diff[17] ? 17'(-w_diff) : 17'(w_diff);
                        r_rem <= '0;
                        r_quo <= '0;
                        r_step <= 5'd1;
                    end else begin
                        r_num <= {r_num[15:0], 1'b0};
                        if (!w_trial[17]) begin
                            r_rem <= w_trial;
                            r_quo <= {r_quo[15:0], 1'b1};
                        end else begin
                            r_rem <= {r_rem[16:0], r_num[16]};
                            r_quo <= {r_quo[15:0], 1'b0};
                        end
                        r_step <= r_step + 5'd1;
                    end
                end
                ibl_pkg::S_WRITE: begin
                    r_score[r_idx] <= 16'(r_old + 16'(w_q));
                    if (r_count[r_idx] != 16'hFFFF) r_count[r_idx] <= r_count[r_idx] + 16'd1;
                end
                ibl_pkg::S_DONE: ;
                default: ;
            endcase
        end
    end

    assign o_duration = r_kind_irr && !r_learn ? r_dur : 4'd0;

endmodule

@@ tb/tb_top.sv @@
// Self-checking bench for irrigation_bandit_learner: bursty command driver, strobe monitor,
// and a bandit-table predictor kept in step with accepted transactions. Depends on ibl_pkg.
module tb_top;

    localparam logic OP_DECIDE = 1'b0;
    localparam logic OP_LEARN  = 1'b1;

    typedef struct packed {
        logic        op;
        logic        healthy;
        logic        water;
        logic [14:0] moist;
        logic [14:0] pmoist;
        logic        pirr;
        logic [3:0]  pdur;
    } t_cmd;

    typedef struct packed {
        logic [1:0] kind;
        logic       irr;
        logic       emg;
        logic [3:0] dur;
        logic       learned;
    } t_outcome;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        start = 1'b0;
    logic        busy;
    logic        i_cfg_we = 1'b0;
    logic [5:0]  i_cfg_data = '0;
    logic        i_op = 1'b0;
    logic        i_system_healthy = 1'b0;
    logic        i_water_available = 1'b0;
    logic [14:0] i_moisture = '0;
    logic [14:0] i_prev_moisture = '0;
    logic        i_prev_irrigated = 1'b0;
    logic [3:0]  i_prev_duration = '0;
    logic        o_valid;
    logic [1:0]  o_decision_kind;
    logic        o_irrigate;
    logic        o_emergency;
    logic [3:0]  o_duration;
    logic        o_learned;

    irrigation_bandit_learner dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy),
        .i_cfg_we(i_cfg_we), .i_cfg_data(i_cfg_data),
        .i_op(i_op), .i_system_healthy(i_system_healthy),
        .i_water_available(i_water_available), .i_moisture(i_moisture),
        .i_prev_moisture(i_prev_moisture), .i_prev_irrigated(i_prev_irrigated),
        .i_prev_duration(i_prev_duration), .o_valid(o_valid),
        .o_decision_kind(o_decision_kind), .o_irrigate(o_irrigate),
        .o_emergency(o_emergency), .o_duration(o_duration), .o_learned(o_learned)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    logic signed [15:0] score_tbl [25];
    logic [15:0]        count_tbl [25];
    logic [5:0]         explore_limit;

    t_cmd     pending_cmds[$];
    t_outcome expected_outcomes[$];
    int       errors = 0;
    int       n_decide = 0;
    int       n_learn = 0;
    int       n_results = 0;
    int       burst_left = 0;
    int       gap_left = 0;
    logic     busy_at_edge = 1'b1;

    function automatic logic [2:0] moisture_bin(logic [14:0] m);
        if (m < 15'd5120) return 3'd0;
        if (m < 15'd7680) return 3'd1;
        if (m < 15'd10240) return 3'd2;
        if (m < 15'd12800) return 3'd3;
        return 3'd4;
    endfunction

    function automatic logic [3:0] slot_duration(int a);
        return 4'(2 * a + 2);
    endfunction

    function automatic int reward_for(logic [14:0] prev, logic [14:0] now);
        int d;
        d = int'(now) - int'(prev);
        if (prev < 15'd7680) begin
            if (d >= 2560 && d <= 7680) return 16384;
            if (d > 7680) return 4096;
            return -8192;
        end
        if (prev >= 15'd11520) begin
            if (d > 2560) return -16384;
            return 8192;
        end
        if (d >= 1280 && d <= 5120) return 16384;
        if (d > 5120) return 4096;
        return -4915;
    endfunction

    function automatic t_outcome predict_outcome(t_cmd c);
        t_outcome r;
        int base, total, best, act, idx, old, upd;
        r = '0;
        if (c.op == OP_DECIDE) begin
            if (!c.healthy) begin
                r.kind = ibl_pkg::KIND_EMERGENCY;
                r.emg = 1'b1;
            end else if (c.water) begin
                r.kind = ibl_pkg::KIND_IRRIGATE;
                r.irr = 1'b1;
                base = 5 * moisture_bin(c.moist);
                total = 0;
                for (int a = 0; a < 5; a++) total += count_tbl[base + a];
                if (total < explore_limit) begin
                    r.dur = slot_duration(total % 5);
                end else begin
                    best = 0;
                    for (int a = 1; a < 5; a++)
                        if (score_tbl[base + a] > score_tbl[base + best]) best = a;
                    r.dur = slot_duration(best);
                end
            end
        end else if (c.pirr) begin
            act = 0;
            for (int a = 4; a >= 0; a--)
                if (c.pdur == slot_duration(a)) act = a;
            idx = 5 * moisture_bin(c.pmoist) + act;
            old = score_tbl[idx];
            upd = old + (reward_for(c.pmoist, c.moist) - old) / (int'(count_tbl[idx]) + 1);
            score_tbl[idx] = 16'(upd);
            if (count_tbl[idx] != 16'hFFFF) count_tbl[idx] = count_tbl[idx] + 16'd1;
            r.learned = 1'b1;
        end
        return r;
    endfunction

    function automatic logic [14:0] rand_moisture();
        case ($urandom_range(0, 9))
            0: return 15'($urandom_range(0, 32767));
            1: return 15'($urandom_range(25600, 32767));
            default: return 15'($urandom_range(0, 16000));
        endcase
    endfunction

    function automatic t_cmd rand_cmd();
        t_cmd c;
        c.op = 1'($urandom_range(0, 1));
        c.healthy = ($urandom_range(0, 9) != 0);
        c.water = ($urandom_range(0, 7) != 0);
        c.pmoist = rand_moisture();
        c.moist = ($urandom_range(0, 2) == 0) ? rand_moisture()
                : 15'(int'(c.pmoist) + $urandom_range(0, 9000) - 1000);
        c.pirr = ($urandom_range(0, 7) != 0);
        c.pdur = ($urandom_range(0, 4) == 0) ? 4'($urandom_range(0, 15))
               : slot_duration($urandom_range(0, 4));
        return c;
    endfunction

    function automatic t_cmd mk(logic op, logic h, logic w, logic [14:0] m, logic [14:0] pm,
                                logic pi, logic [3:0] pd);
        t_cmd c;
        c = {op, h, w, m, pm, pi, pd};
        return c;
    endfunction

    task automatic set_limit(logic [5:0] v);
        @(negedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_data <= v;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        explore_limit = v;
    endtask

    task automatic drain();
        wait (pending_cmds.size() == 0 && expected_outcomes.size() == 0);
        repeat (40) @(negedge i_clk);
    endtask

    // driver: bursts with random gaps, changes on falling edge
    always @(negedge i_clk) begin
        logic accepted;
        accepted = start && !busy_at_edge;
        if (accepted) begin
            void'(pending_cmds.pop_front());
            if (burst_left <= 1) begin
                burst_left = $urandom_range(1, 8);
                gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 40);
            end else begin
                burst_left = burst_left - 1;
            end
        end
        if (!i_rst_n) begin
            start <= 1'b0;
        end else if (gap_left > 0) begin
            gap_left = gap_left - 1;
            start <= 1'b0;
        end else if (pending_cmds.size() > 0) begin
            start <= 1'b1;
            {i_op, i_system_healthy, i_water_available, i_moisture,
             i_prev_moisture, i_prev_irrigated, i_prev_duration} <= pending_cmds[0];
        end else begin
            start <= 1'b0;
        end
    end

    // acceptance capture at the rising edge
    always @(posedge i_clk) begin
        busy_at_edge <= busy;
        if (i_rst_n && start && !busy) begin
            expected_outcomes.push_back(predict_outcome(pending_cmds[0]));
            if (pending_cmds[0].op == OP_DECIDE) n_decide++;
            else n_learn++;
        end
    end

    // monitor
    always @(posedge i_clk) begin
        t_outcome got, want;
        if (i_rst_n && o_valid) begin
            got = {o_decision_kind, o_irrigate, o_emergency, o_duration, o_learned};
            n_results++;
            if (expected_outcomes.size() == 0) begin
                $display("%0t: unexpected result %p", $realtime, got);
                errors++;
            end else begin
                want = expected_outcomes.pop_front();
                if (got.kind !== want.kind)
                    $display("%0t: kind exp %0d got %0d", $realtime, want.kind, got.kind);
                if (got.irr !== want.irr)
                    $display("%0t: irrigate exp %0d got %0d", $realtime, want.irr, got.irr);
                if (got.emg !== want.emg)
                    $display("%0t: emergency exp %0d got %0d", $realtime, want.emg, got.emg);
                if (got.dur !== want.dur)
                    $display("%0t: duration exp %0d got %0d", $realtime, want.dur, got.dur);
                if (got.learned !== want.learned)
                    $display("%0t: learned exp %0d got %0d", $realtime, want.learned,
                             got.learned);
                if (got !== want) errors++;
            end
        end
    end

    initial begin
        #3000000;
        $display("TEST FAILED");
        $finish;
    end

    initial begin
        logic [5:0] limits [4];
        limits = '{6'd0, 6'd63, 6'd3, 6'd50};
        for (int i = 0; i < 25; i++) begin
            score_tbl[i] = '0;
            count_tbl[i] = '0;
        end
        explore_limit = 6'd10;
        repeat (4) @(negedge i_clk);
        i_rst_n <= 1'b1;
        repeat (4) @(negedge i_clk);

        pending_cmds.push_back(mk(OP_DECIDE, 0, 1, 15'd9000, 0, 0, 0));
        pending_cmds.push_back(mk(OP_DECIDE, 1, 0, 15'd9000, 0, 0, 0));
        pending_cmds.push_back(mk(OP_DECIDE, 1, 1, 15'd0, 0, 0, 0));
        pending_cmds.push_back(mk(OP_DECIDE, 1, 1, 15'h7FFF, 0, 0, 0));
        pending_cmds.push_back(mk(OP_LEARN, 1, 1, 15'd5000, 15'd1000, 0, 4'd4));
        pending_cmds.push_back(mk(OP_LEARN, 0, 0, 15'd4000, 15'd1000, 1, 4'd4));
        pending_cmds.push_back(mk(OP_LEARN, 1, 1, 15'h7FFF, 15'd1000, 1, 4'd2));
        pending_cmds.push_back(mk(OP_LEARN, 1, 1, 15'd0, 15'd7000, 1, 4'd15));
        pending_cmds.push_back(mk(OP_LEARN, 1, 1, 15'd14000, 15'd12000, 1, 4'd10));
        pending_cmds.push_back(mk(OP_LEARN, 1, 1, 15'd12000, 15'd12000, 1, 4'd8));
        pending_cmds.push_back(mk(OP_LEARN, 1, 1, 15'd11000, 15'd8000, 1, 4'd6));
        pending_cmds.push_back(mk(OP_LEARN, 1, 1, 15'd15000, 15'd8000, 1, 4'd0));
        pending_cmds.push_back(mk(OP_LEARN, 1, 1, 15'd100, 15'd8000, 1, 4'd6));
        pending_cmds.push_back(mk(OP_LEARN, 1, 1, 15'h7FFF, 15'h7FFF, 1, 4'd10));
        for (int i = 0; i < 6; i++)
            pending_cmds.push_back(mk(OP_DECIDE, 1, 1, 15'(i * 2600), 0, 0, 0));
        drain();

        foreach (limits[k]) begin
            set_limit(limits[k]);
            for (int i = 0; i < 100; i++) pending_cmds.push_back(rand_cmd());
            drain();
        end

        $display("Covered %0d decide and %0d learn transactions, %0d results checked.",
                 n_decide, n_learn, n_results);
        if (errors == 0 && expected_outcomes.size() == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end
endmodule
